// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, constants and the home-slot hash of the linear probe hash map.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int WORD_W    = KEY_W + VAL_W;
    localparam int HASH_SHIFT = 4;
    localparam logic [63:0] HASH_MULT = 64'd1099511628211;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_NULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_HIT,
        S_MISS,
        S_SHIFT,
        S_MOVE,
        S_DONE
    } t_state;

    // low index bits of the product depend only on low index bits of operands
    function automatic t_idx home_slot(input logic [KEY_W-1:0] key);
        logic [2*IDX_W-1:0] prod;
        prod = {{IDX_W{1'b0}}, key[HASH_SHIFT +: IDX_W]}
             * {{IDX_W{1'b0}}, HASH_MULT[IDX_W-1:0]};
        return prod[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/lph_ram.sv =====
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing key/value map with linear probing and backward-shift delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries op, key and entry_value; output
//   channel o_valid/i_stall carries status, found_value and occupancy. One
//   result per item. The block takes one item at a time: o_stall is high
//   from the transfer until the result has been loaded into the output
//   register.
//   Per item: each probed slot takes a table RAM read, then a key compare;
//   then the item is acted on and the result loaded. A delete then tests
//   each following slot, and checks and shifts each occupied one as well.
//   Null keys and unknown ops go straight to loading the result.
//   The single-port-read table RAM sets the per-slot cost.
//   Reset clears all used marks and the entry count; the table RAM needs
//   no clearing. While the receiver stalls, the result holds in
//   the output register; a finished item then waits in its last step with
//   o_stall still high, and no next item is taken until its result loads.
// ----------------------------------------------------------------------------
module linear_probe_hash_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [63:0] i_entry_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_found_value,
    output logic [6:0]  o_occupancy
);

    lph_pkg::t_state r_state, n_state;
    logic [lph_pkg::DEPTH-1:0] r_used, n_used;
    lph_pkg::t_cnt r_count, n_count;
    lph_pkg::t_cnt r_n, n_n;
    lph_pkg::t_idx r_idx, n_idx;
    lph_pkg::t_idx r_gap, n_gap;
    lph_pkg::t_op r_op, n_op;
    logic [63:0] r_key, n_key;
    logic [63:0] r_val, n_val;
    lph_pkg::t_status r_st, n_st;
    logic [63:0] r_fv, n_fv;
    logic r_ovalid, n_ovalid;
    logic [1:0] r_ostatus, n_ostatus;
    logic [63:0] r_ofv, n_ofv;
    logic [6:0] r_oocc, n_oocc;

    logic we;
    lph_pkg::t_idx waddr, raddr;
    logic [lph_pkg::WORD_W-1:0] wdata, rdata;

    logic accept, key_eq, out_free, stays, shift_end;
    lph_pkg::t_idx nxt, home;

    lph_ram #(.WIDTH(lph_pkg::WORD_W), .DEPTH(lph_pkg::DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != lph_pkg::S_IDLE);
    assign out_free  = !r_ovalid || !i_stall;
    assign nxt       = r_idx + 1'b1;
    assign key_eq    = (rdata[lph_pkg::WORD_W-1 -: lph_pkg::KEY_W] == r_key);
    assign home      = lph_pkg::home_slot(rdata[lph_pkg::WORD_W-1 -: lph_pkg::KEY_W]);
    assign stays     = (r_gap <= r_idx) ? ((r_gap < home) && (home <= r_idx))
                                        : ((r_gap < home) || (home <= r_idx));
    assign shift_end = (r_n == lph_pkg::CNT_W'(lph_pkg::DEPTH)) || !r_used[nxt];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lph_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_key == '0 || i_op == lph_pkg::OP_NONE) begin
                        n_state = lph_pkg::S_DONE;
                    end else begin
                        n_state = lph_pkg::S_PROBE;
                    end
                end
            end
            lph_pkg::S_PROBE: n_state = r_used[r_idx] ? lph_pkg::S_CMP : lph_pkg::S_MISS;
            lph_pkg::S_CMP: begin
                if (key_eq) begin
                    n_state = lph_pkg::S_HIT;
                end else if (r_n == lph_pkg::CNT_W'(lph_pkg::DEPTH - 1)) begin
                    n_state = lph_pkg::S_MISS;
                end else begin
                    n_state = lph_pkg::S_PROBE;
                end
            end
            lph_pkg::S_HIT: begin
                n_state = (r_op == lph_pkg::OP_DELETE) ? lph_pkg::S_SHIFT : lph_pkg::S_DONE;
            end
            lph_pkg::S_MISS:  n_state = lph_pkg::S_DONE;
            lph_pkg::S_SHIFT: n_state = shift_end ? lph_pkg::S_DONE : lph_pkg::S_MOVE;
            lph_pkg::S_MOVE:  n_state = lph_pkg::S_SHIFT;
            lph_pkg::S_DONE:  n_state = out_free ? lph_pkg::S_IDLE : lph_pkg::S_DONE;
            default:          n_state = lph_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_used    = r_used;
        n_count   = r_count;
        n_n       = r_n;
        n_idx     = r_idx;
        n_gap     = r_gap;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_st      = r_st;
        n_fv      = r_fv;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_ofv     = r_ofv;
        n_oocc    = r_oocc;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = {r_key, r_val};
        raddr     = r_idx;
        unique case (r_state)
            lph_pkg::S_IDLE: begin
                if (accept) begin
                    n_op  = lph_pkg::t_op'(i_op);
                    n_key = i_key;
                    n_val = i_entry_value;
                    n_idx = lph_pkg::home_slot(i_key);
                    n_n   = '0;
                    n_fv  = '0;
                    n_st  = (i_key == '0) ? lph_pkg::ST_NULL : lph_pkg::ST_NOTFOUND;
                end
            end
            lph_pkg::S_CMP: begin
                if (!key_eq) begin
                    n_idx = nxt;
                    n_n   = r_n + 1'b1;
                end
            end
            lph_pkg::S_HIT: begin
                n_st = lph_pkg::ST_OK;
                unique case (r_op)
                    lph_pkg::OP_INSERT: we = 1'b1;
                    lph_pkg::OP_LOOKUP: n_fv = rdata[lph_pkg::VAL_W-1:0];
                    default: begin
                        n_used[r_idx] = 1'b0;
                        n_gap         = r_idx;
                        n_n           = '0;
                    end
                endcase
            end
            lph_pkg::S_MISS: begin
                if (r_op == lph_pkg::OP_INSERT) begin
                    if (r_count >= lph_pkg::CNT_W'(lph_pkg::DEPTH - 1) || r_used[r_idx]) begin
                        n_st = lph_pkg::ST_FULL;
                    end else begin
                        we            = 1'b1;
                        n_used[r_idx] = 1'b1;
                        n_count       = r_count + 1'b1;
                        n_st          = lph_pkg::ST_OK;
                    end
                end
            end
            lph_pkg::S_SHIFT: begin
                if (shift_end) begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    raddr = nxt;
                    n_idx = nxt;
                end
            end
            lph_pkg::S_MOVE: begin
                n_n = r_n + 1'b1;
                if (!stays) begin
                    we            = 1'b1;
                    waddr         = r_gap;
                    wdata         = rdata;
                    n_used[r_gap] = 1'b1;
                    n_used[r_idx] = 1'b0;
                    n_gap         = r_idx;
                end
            end
            lph_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ofv     = r_fv;
                    n_oocc    = 7'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lph_pkg::S_IDLE;
            r_used   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_gap     <= n_gap;
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_st      <= n_st;
        r_fv      <= n_fv;
        r_ostatus <= n_ostatus;
        r_ofv     <= n_ofv;
        r_oocc    <= n_oocc;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found_value = r_ofv;
    assign o_occupancy   = r_oocc;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lph_pkg::CNT_W'(lph_pkg::DEPTH - 1))
        else $error("entry count above capacity");

    a_count_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lph_pkg::S_IDLE) |-> ($countones(r_used) == 32'(r_count)))
        else $error("entry count disagrees with used marks");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == lph_pkg::S_HIT || r_state == lph_pkg::S_MISS
                || r_state == lph_pkg::S_MOVE))
        else $error("table write outside an update step");

    a_fval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lph_pkg::ST_OK) |-> (o_found_value == '0))
        else $error("found value set on a failed operation");

endmodule
